### hdl/g11lk_pkg.sv
package g11lk_pkg;

    localparam logic [7:0] REG_ARCH_COEF   = 8'd0;
    localparam logic [7:0] REG_GARCH_COEF  = 8'd1;
    localparam logic [7:0] REG_INIT_VAR    = 8'd2;
    localparam logic [7:0] REG_SAMPLE_CNT  = 8'd3;

    localparam logic [14:0] ARCH_RESET     = 15'd3277;
    localparam logic [14:0] GARCH_RESET    = 15'd26214;
    localparam logic [31:0] INIT_VAR_RESET = 32'd65536;
    localparam logic [20:0] COUNT_RESET    = 21'd1024;

    localparam logic [14:0] COEF_MIN       = 15'd328;
    localparam logic [15:0] COEF_SUM_MAX   = 16'd32112;
    localparam logic [15:0] COEF_ONE       = 16'd32768;

    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam logic [63:0] LN2PI_Q16      = 64'd120447;
    localparam logic [63:0] SENTINEL_Q16   = 64'd65536000000000000;

endpackage

### hdl/g11lk_div.sv
module g11lk_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [32:0] rem_reg,  rem_next;
    logic [63:0] quo_reg,  quo_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic        fits;

    // One quotient bit per cycle, restoring form.
    assign shifted = {rem_reg[31:0], quo_reg[63]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[62:0], fits};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/g11lk_log.sv
module g11lk_log
#(
    parameter int LOG_TABLE_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        value,
    output logic               done,
    output logic signed [22:0] ln_q16
);

    localparam int ITERS = (LOG_TABLE_BITS < 16) ? LOG_TABLE_BITS : 16;
    localparam int CW    = $clog2(ITERS + 1);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_NORM = 3'd1;
    localparam logic [2:0] PH_SQR  = 3'd2;
    localparam logic [2:0] PH_MUL  = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]         ph_reg,   ph_next;
    logic [31:0]        n_reg,    n_next;
    logic [4:0]         e_reg,    e_next;
    logic [30:0]        x_reg,    x_next;
    logic [15:0]        frac_reg, frac_next;
    logic [15:0]        bit_reg,  bit_next;
    logic [CW-1:0]      k_reg,    k_next;
    logic signed [54:0] prod_reg, prod_next;
    logic [61:0]        sqr;
    logic [31:0]        sqt;
    logic signed [21:0] l2;
    logic signed [54:0] rounded;

    assign sqr = 62'(x_reg) * 62'(x_reg);
    assign sqt = sqr[61:30];
    // Integer part (exponent minus 16) sits directly above the 16 fraction bits.
    assign l2  = $signed({6'($signed({1'b0, e_reg}) - 6'sd16), frac_reg});

    always_comb
    begin
        ph_next   = ph_reg;
        n_next    = n_reg;
        e_next    = e_reg;
        x_next    = x_reg;
        frac_next = frac_reg;
        bit_next  = bit_reg;
        k_next    = k_reg;
        prod_next = prod_reg;
        unique case (ph_reg)
            PH_IDLE, PH_DONE:
            begin
                if (start)
                begin
                    n_next    = (value == 32'd0) ? 32'd1 : value;
                    e_next    = 5'd31;
                    frac_next = '0;
                    bit_next  = 16'h8000;
                    k_next    = CW'(ITERS);
                    ph_next   = PH_NORM;
                end
            end
            PH_NORM:
            begin
                if (n_reg[31])
                begin
                    x_next  = n_reg[31:1];
                    ph_next = PH_SQR;
                end
                else
                begin
                    n_next = {n_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            PH_SQR:
            begin
                if (sqt[31])
                begin
                    x_next    = sqt[31:1];
                    frac_next = frac_reg | bit_reg;
                end
                else
                begin
                    x_next = sqt[30:0];
                end
                bit_next = {1'b0, bit_reg[15:1]};
                k_next   = k_reg - CW'(1);
                if (k_reg == CW'(1))
                begin
                    ph_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                prod_next = 55'(l2) * $signed({23'd0, g11lk_pkg::LN2_Q32});
                ph_next   = PH_DONE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
            k_reg  <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
            k_reg  <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        e_reg    <= e_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        bit_reg  <= bit_next;
        prod_reg <= prod_next;
    end

    // Divide by 2^32 with truncation toward zero.
    assign rounded = prod_reg + (prod_reg[54] ? 55'sd4294967295 : 55'sd0);
    assign ln_q16  = 23'(rounded >>> 32);
    assign done    = (ph_reg == PH_DONE) && !start;

endmodule

### hdl/garch11_likelihood_top.sv
// Channel | Direction | Beat contents
// s_axis  | in        | tdata[31:0] residual
// m_axis  | out       | tdata: next_variance, running_likelihood; tuser: coef_valid, overflow;
//         |           | tlast: run_last
// cfg     | in        | cfg_index selects the register, cfg_data is the value
// The bit-serial 64-bit divider sets how long one residual takes,
// with the log normalization and squaring running beside it.
// The input is ready only while the sequencer idles and no register write is offered;
// a finished result waits in the output register and a new residual may be accepted meanwhile.
// Reset restores the register defaults and clears the accumulator and run counter.
module garch11_likelihood_top
#(
    parameter int LOG_TABLE_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] residual
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] next_variance, [95:32] running_likelihood
    output logic [1:0]   m_axis_tuser,   // [0] coef_valid, [1] overflow
    output logic         m_axis_tlast,   // run_last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_START = 4'd2;
    localparam logic [3:0] ST_MA    = 4'd3;
    localparam logic [3:0] ST_MG    = 4'd4;
    localparam logic [3:0] ST_WAIT  = 4'd5;
    localparam logic [3:0] ST_PLO   = 4'd6;
    localparam logic [3:0] ST_PHI   = 4'd7;
    localparam logic [3:0] ST_ACC   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]  st_reg, st_next;

    logic [14:0] arch_reg;
    logic [14:0] garch_reg;
    logic [31:0] init_reg;
    logic [20:0] count_reg;

    logic [31:0]        var_reg;
    logic signed [63:0] acc_reg;
    logic [20:0]        cnt_reg;
    logic               ovf_reg;

    logic [31:0]        mag_reg;
    logic [63:0]        sq_reg;
    logic [62:0]        pa_reg;
    logic [46:0]        pg_reg;
    logic signed [63:0] s_reg;
    logic [52:0]        plo_reg;
    logic signed [53:0] phi_reg;
    logic [31:0]        hn_reg;
    logic signed [63:0] accn_reg;
    logic               ovfn_reg;

    logic        o_valid_reg;
    logic [95:0] o_data_reg;
    logic [1:0]  o_user_reg;
    logic        o_last_reg;

    logic               div_start, div_done, log_done;
    logic [63:0]        quot;
    logic signed [22:0] ln_val;
    logic [31:0]        divisor;

    logic [31:0]        raw_mag;
    logic [20:0]        count_eff;
    logic [20:0]        m_val;
    logic [15:0]        coef_sum;
    logic [15:0]        omega;
    logic [47:0]        sq16;
    logic [63:0]        vsum;
    logic [48:0]        vround;
    logic               var_sat;
    logic signed [85:0] full;
    logic               term_sat;
    logic signed [85:0] half;
    logic signed [63:0] term;
    logic signed [64:0] asum;
    logic               acc_sat;
    logic signed [63:0] acc_new;
    logic               coef_ok;
    logic               last;
    logic               in_fire, cfg_fire, out_load;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    // A pending register write goes first so that it never shares an edge with a residual.
    assign s_axis_tready = (st_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready     = (st_reg == ST_IDLE);
    assign out_load = (st_reg == ST_OUT) && (!o_valid_reg || m_axis_tready);

    // Two's-complement magnitude; the most negative code maps to 2^31.
    assign raw_mag = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;

    assign count_eff = (count_reg < 21'd2) ? 21'd2 : count_reg;
    assign m_val     = count_eff - 21'd1;
    assign coef_sum  = {1'b0, arch_reg} + {1'b0, garch_reg};
    assign omega     = (coef_sum >= g11lk_pkg::COEF_ONE) ? 16'd0
                                                         : (g11lk_pkg::COEF_ONE - coef_sum);
    assign coef_ok   = (arch_reg >= g11lk_pkg::COEF_MIN) && (garch_reg >= g11lk_pkg::COEF_MIN)
                       && (coef_sum <= g11lk_pkg::COEF_SUM_MAX);
    assign sq16      = 48'((sq_reg + 64'd32768) >> 16);
    assign divisor   = (var_reg == 32'd0) ? 32'd1 : var_reg;
    assign div_start = (st_reg == ST_START);

    assign vsum    = {32'd0, omega, 16'd0} + {1'b0, pa_reg} + {17'd0, pg_reg};
    assign vround  = 49'((vsum + 64'd16384) >> 15);
    assign var_sat = (vround[48:32] != 17'd0);

    assign full     = ({{32{phi_reg[53]}}, phi_reg} <<< 32) + $signed({33'd0, plo_reg});
    assign term_sat = !((full[85:63] == '0) || (full[85:63] == '1));
    assign half     = (full + (full[85] ? 86'sd1 : 86'sd0)) >>> 1;
    assign term     = term_sat ? (full[85] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                               : half[63:0];
    assign asum     = {acc_reg[63], acc_reg} + {term[63], term};
    assign acc_sat  = (asum[64] != asum[63]);
    assign acc_new  = acc_sat ? (asum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                              : asum[63:0];

    assign last = ({1'b0, cnt_reg} + 22'd1) >= {1'b0, m_val};

    g11lk_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sq_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quot)
    );

    g11lk_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .value  (var_reg),
        .done   (log_done),
        .ln_q16 (ln_val)
    );

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (in_fire) st_next = ST_SQ;
            ST_SQ:    st_next = ST_START;
            ST_START: st_next = ST_MA;
            ST_MA:    st_next = ST_MG;
            ST_MG:    st_next = ST_WAIT;
            ST_WAIT:  if (div_done && log_done) st_next = ST_PLO;
            ST_PLO:   st_next = ST_PHI;
            ST_PHI:   st_next = ST_ACC;
            ST_ACC:   st_next = ST_OUT;
            ST_OUT:   if (out_load) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            arch_reg    <= g11lk_pkg::ARCH_RESET;
            garch_reg   <= g11lk_pkg::GARCH_RESET;
            init_reg    <= g11lk_pkg::INIT_VAR_RESET;
            count_reg   <= g11lk_pkg::COUNT_RESET;
            var_reg     <= g11lk_pkg::INIT_VAR_RESET;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    g11lk_pkg::REG_ARCH_COEF:  arch_reg  <= cfg_data[14:0];
                    g11lk_pkg::REG_GARCH_COEF: garch_reg <= cfg_data[14:0];
                    g11lk_pkg::REG_INIT_VAR:
                    begin
                        init_reg <= cfg_data;
                        if (cnt_reg == 21'd0)
                        begin
                            var_reg <= cfg_data;
                        end
                    end
                    g11lk_pkg::REG_SAMPLE_CNT: count_reg <= cfg_data[20:0];
                    default: ;
                endcase
            end
            if (out_load)
            begin
                o_valid_reg <= 1'b1;
                if (last)
                begin
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    ovf_reg <= 1'b0;
                    var_reg <= init_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 21'd1;
                    acc_reg <= accn_reg;
                    ovf_reg <= ovfn_reg;
                    var_reg <= hn_reg;
                end
            end
            else if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mag_reg <= raw_mag;
        end
        unique case (st_reg)
            ST_SQ:   sq_reg  <= 64'(mag_reg) * 64'(mag_reg);
            ST_MA:   pa_reg  <= 63'(arch_reg) * 63'(sq16);
            ST_MG:   pg_reg  <= 47'(garch_reg) * 47'(var_reg);
            ST_WAIT: s_reg   <= $signed(g11lk_pkg::LN2PI_Q16) + 64'(ln_val) + $signed(quot);
            ST_PLO:  plo_reg <= 53'(s_reg[31:0]) * 53'(m_val);
            ST_PHI:  phi_reg <= 54'($signed(s_reg[63:32])) * $signed({33'd0, m_val});
            ST_ACC:
            begin
                hn_reg   <= var_sat ? 32'hFFFF_FFFF : vround[31:0];
                accn_reg <= acc_new;
                ovfn_reg <= ovf_reg || term_sat || acc_sat || var_sat;
            end
            default: ;
        endcase
        if (out_load)
        begin
            o_data_reg <= {(coef_ok ? accn_reg : $signed(g11lk_pkg::SENTINEL_Q16)), hn_reg};
            o_user_reg <= {ovfn_reg, coef_ok};
            o_last_reg <= last;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;
    assign m_axis_tuser  = o_user_reg;
    assign m_axis_tlast  = o_last_reg;

endmodule

### dv/garch11_likelihood_top_tb.sv
module garch11_likelihood_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LOG_BITS = 8;

    typedef struct packed {
        logic [31:0] next_variance;
        logic [63:0] likelihood;
        logic        coef_valid;
        logic        run_last;
        logic        overflow;
    } garch_result_t;

    typedef struct {
        logic        is_cfg;
        logic        wait_idle;
        logic [7:0]  index;
        logic [31:0] data;
    } stim_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;

    garch11_likelihood_top #(.LOG_TABLE_BITS(LOG_BITS)) dut (.*);

    // Predictor state.
    logic [14:0] arch_q = g11lk_pkg::ARCH_RESET;
    logic [14:0] garch_q = g11lk_pkg::GARCH_RESET;
    logic [31:0] init_var_q = g11lk_pkg::INIT_VAR_RESET;
    logic [20:0] count_q = g11lk_pkg::COUNT_RESET;
    logic [31:0] var_q = g11lk_pkg::INIT_VAR_RESET;
    logic signed [63:0] acc_q = '0;
    logic [20:0] counter_q = '0;
    logic        ovf_q = 1'b0;

    garch_result_t expected_results[$];
    stim_item_t    pending[$];
    int            mismatches;
    int            idle_cycles;
    int            wait_left;
    int            hold_left;
    int            recv_wait;
    int            results_seen;
    logic          done;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [63:0] log_q16(input logic [31:0] h_in);
        logic [31:0] h;
        int e;
        logic [63:0] x;
        logic signed [63:0] l2;
        logic signed [127:0] prod;
        h = (h_in == 0) ? 32'd1 : h_in;
        e = 31;
        while (e > 0 && h[e] == 1'b0) e--;
        if (e <= 30) x = 64'(h) << (30 - e);
        else x = 64'(h) >> 1;
        l2 = 64'(e - 16) * 65536;
        for (int k = 1; k <= LOG_BITS && k <= 16; k++)
        begin
            x = (x * x) >> 30;
            if (x >= 64'h8000_0000)
            begin
                x = x >> 1;
                l2 = l2 + (64'sd1 <<< (16 - k));
            end
        end
        prod = 128'(l2) * $signed({96'd0, g11lk_pkg::LN2_Q32});
        return 64'(prod / 128'sd4294967296);
    endfunction

    function automatic void apply_config(input logic [7:0] idx, input logic [31:0] val);
        case (idx)
            g11lk_pkg::REG_ARCH_COEF:  arch_q = val[14:0];
            g11lk_pkg::REG_GARCH_COEF: garch_q = val[14:0];
            g11lk_pkg::REG_INIT_VAR:
            begin
                init_var_q = val;
                if (counter_q == 0) var_q = val;
            end
            g11lk_pkg::REG_SAMPLE_CNT: count_q = val[20:0];
            default: ;
        endcase
    endfunction

    function automatic garch_result_t predict_residual(input logic [31:0] raw);
        logic [63:0] mag, sq, sq16, sum, omega, quot, divisor;
        logic [63:0] cnt;
        logic signed [63:0] m, s, term, imax, imin;
        logic signed [127:0] wide;
        logic valid, last;
        garch_result_t res;
        imax = 64'h7FFF_FFFF_FFFF_FFFF;
        imin = 64'h8000_0000_0000_0000;
        mag = {32'd0, (raw[31] ? (~raw + 32'd1) : raw)};
        if (raw == 32'h8000_0000) mag = 64'h8000_0000;
        sq = mag * mag;
        cnt = (count_q < 2) ? 64'd2 : 64'(count_q);
        m = cnt - 1;
        valid = arch_q >= g11lk_pkg::COEF_MIN && garch_q >= g11lk_pkg::COEF_MIN
            && 16'(arch_q) + 16'(garch_q) <= g11lk_pkg::COEF_SUM_MAX;
        divisor = (var_q == 0) ? 64'd1 : 64'(var_q);
        quot = sq / divisor;
        s = $signed(g11lk_pkg::LN2PI_Q16) + log_q16(var_q) + $signed(quot);
        wide = 128'(s) * 128'(m);
        if (wide > 128'(imax))
        begin
            term = imax;
            ovf_q = 1'b1;
        end
        else if (wide < 128'(imin))
        begin
            term = imin;
            ovf_q = 1'b1;
        end
        else term = 64'(wide) / 2;
        wide = 128'(acc_q) + 128'(term);
        if (wide > 128'(imax))
        begin
            acc_q = imax;
            ovf_q = 1'b1;
        end
        else if (wide < 128'(imin))
        begin
            acc_q = imin;
            ovf_q = 1'b1;
        end
        else acc_q = 64'(wide);
        omega = (17'(arch_q) + 17'(garch_q) >= 17'(g11lk_pkg::COEF_ONE)) ? 64'd0
            : 64'(g11lk_pkg::COEF_ONE) - arch_q - garch_q;
        sq16 = (sq + 64'd32768) >> 16;
        sum = (omega << 16) + 64'(arch_q) * sq16 + 64'(garch_q) * 64'(var_q);
        sum = (sum + 64'd16384) >> 15;
        if (sum > 64'hFFFF_FFFF)
        begin
            var_q = 32'hFFFF_FFFF;
            ovf_q = 1'b1;
        end
        else var_q = sum[31:0];
        last = 64'(counter_q) + 1 >= cnt - 1;
        res.next_variance = var_q;
        res.likelihood = valid ? acc_q : g11lk_pkg::SENTINEL_Q16;
        res.coef_valid = valid;
        res.run_last = last;
        res.overflow = ovf_q;
        if (last)
        begin
            counter_q = 0;
            acc_q = 0;
            ovf_q = 1'b0;
            var_q = init_var_q;
        end
        else counter_q = counter_q + 1;
        return res;
    endfunction

    function automatic logic [31:0] rand_residual();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    task automatic add_residual(input logic [31:0] r);
        stim_item_t it;
        it.is_cfg = 1'b0;
        it.wait_idle = 1'b0;
        it.index = '0;
        it.data = r;
        pending.insert(pending.size(), it);
    endtask

    task automatic add_config(input logic [7:0] idx, input logic [31:0] val);
        stim_item_t it;
        it.is_cfg = 1'b1;
        it.wait_idle = 1'b1;
        it.index = idx;
        it.data = val;
        pending.insert(pending.size(), it);
    endtask

    task automatic add_setting(input logic [14:0] a, input logic [14:0] g,
                               input logic [31:0] v, input logic [20:0] n);
        add_config(g11lk_pkg::REG_ARCH_COEF, 32'(a));
        add_config(g11lk_pkg::REG_GARCH_COEF, 32'(g));
        add_config(g11lk_pkg::REG_INIT_VAR, v);
        add_config(g11lk_pkg::REG_SAMPLE_CNT, 32'(n));
    endtask

    // Driver: one item in flight at a time, either a residual or a register write.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            cfg_valid     <= 1'b0;
            cfg_index     <= '0;
            cfg_data      <= '0;
            wait_left     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.insert(expected_results.size(),
                                        predict_residual(s_axis_tdata));
                s_axis_tvalid <= 1'b0;
                wait_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            end
            else if (cfg_valid && cfg_ready)
            begin
                apply_config(cfg_index, cfg_data);
                cfg_valid <= 1'b0;
            end
            else if (!s_axis_tvalid && !cfg_valid && pending.size() > 0)
            begin
                if (wait_left > 0)
                    wait_left <= wait_left - 1;
                else if (pending[0].wait_idle
                         && (expected_results.size() > 0 || idle_cycles < 100))
                    ;
                else if (pending[0].is_cfg)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending[0].index;
                    cfg_data  <= pending[0].data;
                    void'(pending.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending[0].data;
                    void'(pending.pop_front());
                end
            end
        end
    end

    // Monitor and receiver stall control.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
            hold_left     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                garch_result_t got, want;
                got.next_variance = m_axis_tdata[31:0];
                got.likelihood    = m_axis_tdata[95:32];
                got.coef_valid    = m_axis_tuser[0];
                got.overflow      = m_axis_tuser[1];
                got.run_last      = m_axis_tlast;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result beat %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
                results_seen++;
                m_axis_tready <= 1'b0;
                recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
                // Hold off long enough for the input to back up, once for sure and
                // now and then after that.
                if (results_seen == 40 || $urandom_range(0, 199) == 0) hold_left <= 600;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (recv_wait > 0)
                recv_wait <= recv_wait - 1;
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready)
            || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (!done && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        stim_item_t pause;
        done = 1'b0;
        rst_n = 1'b0;

        // Directed part: default setting, field extremes and corner values.
        add_residual(32'h0000_0000);
        add_residual(32'h7FFF_FFFF);
        add_residual(32'h8000_0000);
        add_residual(32'hFFFF_FFFF);
        add_residual(32'h0001_0000);
        add_setting(15'd0, 15'd0, 32'd1, 21'd0);          // invalid, short count
        add_residual(32'h0000_0000);
        add_residual(32'h8000_0000);
        add_setting(15'd32767, 15'd32767, 32'hFFFF_FFFF, 21'd3);  // saturating
        add_residual(32'h7FFF_FFFF);
        add_residual(32'h8000_0001);
        add_residual(32'h0000_0001);
        add_setting(15'd328, 15'd31784, 32'd0, 21'd4);    // edge of window, zero var
        add_residual(32'h0000_0000);
        add_residual(32'h0002_0000);
        add_config(8'd7, 32'hFFFF_FFFF);                  // ignored index
        add_setting(15'd327, 15'd328, 32'd65536, 21'd1048576);
        add_residual(32'h0000_8000);
        add_residual(32'hFFFF_8000);
        add_config(g11lk_pkg::REG_SAMPLE_CNT, 32'h001F_FFFF);
        add_residual(32'h0001_0000);
        // A smaller count than the counter ends the run next residual.
        add_config(g11lk_pkg::REG_SAMPLE_CNT, 32'd2);
        add_residual(32'h0001_0000);
        pause.is_cfg = 1'b0;
        pause.wait_idle = 1'b1;
        pause.index = '0;
        pause.data = 32'h0000_4000;
        pending.insert(pending.size(), pause);

        for (int blk = 0; blk < 30; blk++)
        begin
            case (blk % 5)
                0: add_setting(g11lk_pkg::ARCH_RESET, g11lk_pkg::GARCH_RESET,
                               g11lk_pkg::INIT_VAR_RESET, 21'($urandom_range(2, 40)));
                1: add_setting(15'($urandom), 15'($urandom), $urandom,
                               21'($urandom_range(0, 60)));
                2: add_setting(15'($urandom_range(328, 3000)),
                               15'($urandom_range(20000, 29000)),
                               $urandom_range(1, 32'h0010_0000), 21'($urandom_range(2, 8)));
                3: add_setting(15'($urandom_range(0, 400)), 15'($urandom_range(31000, 32767)),
                               $urandom_range(1, 1000), 21'($urandom));
                default: add_setting(15'($urandom_range(1000, 8000)),
                                     15'($urandom_range(10000, 24000)),
                                     $urandom, 21'($urandom_range(2, 100)));
            endcase
            for (int i = 0; i < 50; i++)
                add_residual(rand_residual());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || s_axis_tvalid || cfg_valid
               || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        done = 1'b1;
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### garch11_likelihood_top.f
hdl/g11lk_pkg.sv
hdl/g11lk_div.sv
hdl/g11lk_log.sv
hdl/garch11_likelihood_top.sv
dv/garch11_likelihood_top_tb.sv
